### hw/rtl/qoi_pkg.sv
// Shared types and constants for the QOI pixel encoder.
package qoi_pkg;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    localparam pixel_t PIXEL_RESET = '{alpha: 8'hff, blue: 8'h00, green: 8'h00, red: 8'h00};

    localparam logic [7:0] OP_INDEX = 8'h00;
    localparam logic [7:0] OP_DIFF  = 8'h40;
    localparam logic [7:0] OP_LUMA  = 8'h80;
    localparam logic [7:0] OP_RUN   = 8'hc0;
    localparam logic [7:0] OP_RGB   = 8'hfe;
    localparam logic [7:0] OP_RGBA  = 8'hff;

    localparam logic [5:0] RUN_CAP  = 6'd62;

    localparam logic [7:0] PAD_BYTE = 8'h00;
    localparam logic [7:0] PAD_LAST = 8'h01;

    // byte buffer layout: run byte, up to five op bytes, eight padding bytes
    localparam int         NUM_SLOTS     = 14;
    localparam int         SLOT_RUN      = 0;
    localparam int         SLOT_OP       = 1;
    localparam int         NUM_OP        = 5;
    localparam int         SLOT_PAD      = 6;
    localparam logic [3:0] SLOT_PAD_LAST = 4'd13;

endpackage

### hw/rtl/qoi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qoi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/qoi_pixel_encoder_top.sv
// QOI pixel encoder: pixel register, combinational op encode, byte buffer drained one word
// a cycle while m_tready is high. One pixel per cycle while each pixel yields at most one
// byte and m_tready is high; a pixel that yields more holds the encode stage until its last
// byte is on the single-byte output port. Reset: clears handshake state, run counter,
// previous pixel and the index valid bits; index RAM contents are masked by the valid bits,
// no clearing pass. A final pixel clears all of these except the handshake state.
module qoi_pixel_encoder_top #(
    parameter int INDEX_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  logic        s_tlast,   // final_pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // code_byte[7:0]
    output logic        m_tlast,   // run_end
    output logic        m_tuser    // image_end[0]
);

    localparam int IDX_W = $clog2(INDEX_ENTRIES);

    qoi_pkg::pixel_t in_px;
    logic [11:0]     hash_sum;
    logic [IDX_W-1:0] in_slot;
    logic            accept;
    logic            fire;

    logic              s1_valid_reg, s1_valid_next;
    qoi_pkg::pixel_t   s1_px_reg;
    logic              s1_last_reg;
    logic [IDX_W-1:0]  s1_slot_reg;

    qoi_pkg::pixel_t   prev_reg, prev_next;
    logic [5:0]        run_reg, run_next;
    logic [INDEX_ENTRIES-1:0] valid_reg, valid_next;

    logic              byp_valid_reg, byp_valid_next;
    logic [IDX_W-1:0]  byp_slot_reg;
    qoi_pkg::pixel_t   byp_data_reg;

    logic [31:0]       ram_rdata;
    qoi_pkg::pixel_t   entry;

    logic [qoi_pkg::NUM_SLOTS-1:0] mask_reg, mask_next, new_mask;
    logic [7:0]        run_byte_reg, new_run_byte;
    logic [7:0]        op_reg [qoi_pkg::NUM_OP];
    logic [7:0]        new_op [qoi_pkg::NUM_OP];
    logic              wr_en;

    logic              same, hit;
    logic [5:0]        run_inc;
    logic [7:0]        dr, dg, db, vgr, vgb;
    logic [7:0]        dr_b, dg_b, db_b, dg_b32, vgr_b, vgb_b;
    logic              is_diff, is_luma;

    logic [7:0]        slot_bytes [qoi_pkg::NUM_SLOTS];
    logic [3:0]        ptr;
    logic              single;
    logic              out_hs;

    // pixel input side and index read
    assign in_px    = qoi_pkg::pixel_t'(s_tdata);
    assign hash_sum = 12'(in_px.red) * 12'd3 + 12'(in_px.green) * 12'd5
                    + 12'(in_px.blue) * 12'd7 + 12'(in_px.alpha) * 12'd11;
    assign in_slot  = hash_sum[IDX_W-1:0];

    assign out_hs   = m_tvalid && m_tready;
    assign single   = (mask_reg & (mask_reg - 1'b1)) == '0;
    assign fire     = s1_valid_reg && ((mask_reg == '0) || (out_hs && single));
    assign s_tready = !s1_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    qoi_ram #(
        .WIDTH (32),
        .DEPTH (INDEX_ENTRIES)
    ) u_index (
        .clk   (clk),
        .we    (fire && wr_en),
        .waddr (s1_slot_reg),
        .wdata (s1_px_reg),
        .re    (accept),
        .raddr (in_slot),
        .rdata (ram_rdata)
    );

    // encode stage
    always_comb
    begin
        if (byp_valid_reg && (byp_slot_reg == s1_slot_reg))
        begin
            entry = byp_data_reg;
        end
        else if (valid_reg[s1_slot_reg])
        begin
            entry = qoi_pkg::pixel_t'(ram_rdata);
        end
        else
        begin
            entry = '0;
        end

        same    = s1_px_reg == prev_reg;
        hit     = entry == s1_px_reg;
        run_inc = run_reg + 6'd1;

        dr  = s1_px_reg.red - prev_reg.red;
        dg  = s1_px_reg.green - prev_reg.green;
        db  = s1_px_reg.blue - prev_reg.blue;
        vgr = dr - dg;
        vgb = db - dg;

        dr_b   = dr + 8'd2;
        dg_b   = dg + 8'd2;
        db_b   = db + 8'd2;
        dg_b32 = dg + 8'd32;
        vgr_b  = vgr + 8'd8;
        vgb_b  = vgb + 8'd8;

        is_diff = ($signed(dr) > -8'sd3) && ($signed(dr) < 8'sd2)
               && ($signed(dg) > -8'sd3) && ($signed(dg) < 8'sd2)
               && ($signed(db) > -8'sd3) && ($signed(db) < 8'sd2);
        is_luma = ($signed(vgr) > -8'sd9) && ($signed(vgr) < 8'sd8)
               && ($signed(dg) > -8'sd33) && ($signed(dg) < 8'sd32)
               && ($signed(vgb) > -8'sd9) && ($signed(vgb) < 8'sd8);

        new_mask     = '0;
        new_run_byte = qoi_pkg::OP_RUN | {2'b00, run_reg};
        for (int i = 0; i < qoi_pkg::NUM_OP; i++)
        begin
            new_op[i] = '0;
        end
        wr_en    = 1'b0;
        run_next = run_reg;

        if (same)
        begin
            run_next = run_inc;
            if ((run_inc == qoi_pkg::RUN_CAP) || s1_last_reg)
            begin
                new_mask[qoi_pkg::SLOT_RUN] = 1'b1;
                run_next = '0;
            end
        end
        else
        begin
            run_next = '0;
            if (run_reg != '0)
            begin
                new_mask[qoi_pkg::SLOT_RUN] = 1'b1;
                new_run_byte = qoi_pkg::OP_RUN | {2'b00, run_reg - 6'd1};
            end
            if (hit)
            begin
                new_op[0] = qoi_pkg::OP_INDEX | 8'(s1_slot_reg);
                new_mask[qoi_pkg::SLOT_OP] = 1'b1;
            end
            else
            begin
                wr_en = 1'b1;
                if (s1_px_reg.alpha == prev_reg.alpha)
                begin
                    if (is_diff)
                    begin
                        new_op[0] = qoi_pkg::OP_DIFF | {2'b00, dr_b[1:0], dg_b[1:0], db_b[1:0]};
                        new_mask[qoi_pkg::SLOT_OP] = 1'b1;
                    end
                    else if (is_luma)
                    begin
                        new_op[0] = qoi_pkg::OP_LUMA | {2'b00, dg_b32[5:0]};
                        new_op[1] = {vgr_b[3:0], vgb_b[3:0]};
                        new_mask[qoi_pkg::SLOT_OP +: 2] = '1;
                    end
                    else
                    begin
                        new_op[0] = qoi_pkg::OP_RGB;
                        new_op[1] = s1_px_reg.red;
                        new_op[2] = s1_px_reg.green;
                        new_op[3] = s1_px_reg.blue;
                        new_mask[qoi_pkg::SLOT_OP +: 4] = '1;
                    end
                end
                else
                begin
                    new_op[0] = qoi_pkg::OP_RGBA;
                    new_op[1] = s1_px_reg.red;
                    new_op[2] = s1_px_reg.green;
                    new_op[3] = s1_px_reg.blue;
                    new_op[4] = s1_px_reg.alpha;
                    new_mask[qoi_pkg::SLOT_OP +: 5] = '1;
                end
            end
        end

        if (s1_last_reg)
        begin
            new_mask[qoi_pkg::SLOT_PAD +: 8] = '1;
        end
    end

    // state updates
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        prev_next      = prev_reg;
        valid_next     = valid_reg;
        byp_valid_next = byp_valid_reg;
        mask_next      = mask_reg;

        if (out_hs)
        begin
            mask_next = mask_reg & (mask_reg - 1'b1);
        end

        if (fire)
        begin
            s1_valid_next = 1'b0;
            mask_next     = new_mask;
            if (s1_last_reg)
            begin
                prev_next  = qoi_pkg::PIXEL_RESET;
                valid_next = '0;
            end
            else
            begin
                prev_next = s1_px_reg;
                if (wr_en)
                begin
                    valid_next[s1_slot_reg] = 1'b1;
                end
            end
        end

        if (accept)
        begin
            s1_valid_next  = 1'b1;
            byp_valid_next = fire && wr_en && !s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            prev_reg      <= qoi_pkg::PIXEL_RESET;
            run_reg       <= '0;
            valid_reg     <= '0;
            byp_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            prev_reg      <= prev_next;
            valid_reg     <= valid_next;
            byp_valid_reg <= byp_valid_next;
            mask_reg      <= mask_next;
            if (fire)
            begin
                run_reg <= s1_last_reg ? 6'd0 : run_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= in_px;
            s1_last_reg  <= s_tlast;
            s1_slot_reg  <= in_slot;
            byp_slot_reg <= s1_slot_reg;
            byp_data_reg <= s1_px_reg;
        end
        if (fire)
        begin
            run_byte_reg <= new_run_byte;
            for (int i = 0; i < qoi_pkg::NUM_OP; i++)
            begin
                op_reg[i] <= new_op[i];
            end
        end
    end

    // output side: lowest pending slot goes out first
    always_comb
    begin
        slot_bytes[qoi_pkg::SLOT_RUN] = run_byte_reg;
        for (int i = 0; i < qoi_pkg::NUM_OP; i++)
        begin
            slot_bytes[qoi_pkg::SLOT_OP + i] = op_reg[i];
        end
        for (int i = qoi_pkg::SLOT_PAD; i < qoi_pkg::NUM_SLOTS - 1; i++)
        begin
            slot_bytes[i] = qoi_pkg::PAD_BYTE;
        end
        slot_bytes[qoi_pkg::NUM_SLOTS - 1] = qoi_pkg::PAD_LAST;

        ptr = '0;
        for (int i = qoi_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                ptr = 4'(i);
            end
        end
    end

    assign m_tvalid = mask_reg != '0;
    assign m_tdata  = slot_bytes[ptr];
    assign m_tlast  = single;
    assign m_tuser  = ptr == qoi_pkg::SLOT_PAD_LAST;

    // checks
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("image end without word end");

    a_run_cap: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= qoi_pkg::RUN_CAP)
        else $error("run counter over cap");

    a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_last_reg |=> (valid_reg == '0) && (run_reg == '0)
                                && (prev_reg == qoi_pkg::PIXEL_RESET))
        else $error("image state not cleared after final pixel");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_tready)
        else $error("input stalled with empty encode stage");

endmodule

### bench/qoi_pixel_encoder_top_tb.sv
// Self-checking testbench for the QOI pixel encoder: predicts the op bytes per pixel and checks the byte stream.
module qoi_pixel_encoder_top_tb;

    localparam int INDEX_ENTRIES = 64;
    localparam int IDLE_LIMIT    = 2000;
    localparam int TOTAL_PIXELS  = 380;
    localparam int END_CYCLES    = 16;

    typedef struct packed {
        logic [7:0] code;
        logic       run_end;
        logic       image_end;
    } code_word_t;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_e;

    class qoi_stream_board;
        qoi_pkg::pixel_t prev_px;
        qoi_pkg::pixel_t color_slots[INDEX_ENTRIES];
        int unsigned run_len;
        code_word_t  expected_bytes[$];
        int unsigned errors   = 0;
        int unsigned pixels   = 0;
        int unsigned images   = 0;
        int unsigned bytes_ok = 0;
        int unsigned n_run    = 0;
        int unsigned n_cap    = 0;
        int unsigned n_index  = 0;
        int unsigned n_diff   = 0;
        int unsigned n_luma   = 0;
        int unsigned n_rgb    = 0;
        int unsigned n_rgba   = 0;

        function new();
            clear_image();
        endfunction

        function void clear_image();
            prev_px = qoi_pkg::PIXEL_RESET;
            foreach (color_slots[i])
                color_slots[i] = '0;
            run_len = 0;
        endfunction

        function void put(logic [7:0] code);
            code_word_t w;
            w = '0;
            w.code = code;
            expected_bytes.push_back(w);
        endfunction

        function void flush_run();
            put(qoi_pkg::OP_RUN | 8'(run_len - 1));
            n_run++;
            if (run_len == qoi_pkg::RUN_CAP)
                n_cap++;
            run_len = 0;
        endfunction

        // expected op bytes for one accepted pixel
        function void encode_pixel(qoi_pkg::pixel_t px, logic last);
            int         base;
            int         slot;
            logic [7:0] ur;
            logic [7:0] ug;
            logic [7:0] ub;
            byte        vr;
            byte        vg;
            byte        vb;
            byte        vgr;
            byte        vgb;
            base = expected_bytes.size();
            pixels++;
            if (px == prev_px)
            begin
                run_len++;
                if (run_len == qoi_pkg::RUN_CAP || last)
                    flush_run();
            end
            else
            begin
                if (run_len > 0)
                    flush_run();
                slot = (int'(px.red) * 3 + int'(px.green) * 5 + int'(px.blue) * 7
                        + int'(px.alpha) * 11) % INDEX_ENTRIES;
                if (color_slots[slot] == px)
                begin
                    put(qoi_pkg::OP_INDEX | 8'(slot));
                    n_index++;
                end
                else
                begin
                    color_slots[slot] = px;
                    if (px.alpha != prev_px.alpha)
                    begin
                        put(qoi_pkg::OP_RGBA);
                        put(px.red);
                        put(px.green);
                        put(px.blue);
                        put(px.alpha);
                        n_rgba++;
                    end
                    else
                    begin
                        ur  = px.red - prev_px.red;
                        ug  = px.green - prev_px.green;
                        ub  = px.blue - prev_px.blue;
                        vr  = ur;
                        vg  = ug;
                        vb  = ub;
                        vgr = ur - ug;
                        vgb = ub - ug;
                        if (vr > -3 && vr < 2 && vg > -3 && vg < 2 && vb > -3 && vb < 2)
                        begin
                            put(qoi_pkg::OP_DIFF
                                | 8'(((vr + 2) << 4) | ((vg + 2) << 2) | (vb + 2)));
                            n_diff++;
                        end
                        else if (vgr > -9 && vgr < 8 && vg > -33 && vg < 32
                                 && vgb > -9 && vgb < 8)
                        begin
                            put(qoi_pkg::OP_LUMA | 8'(vg + 32));
                            put(8'(((vgr + 8) << 4) | (vgb + 8)));
                            n_luma++;
                        end
                        else
                        begin
                            put(qoi_pkg::OP_RGB);
                            put(px.red);
                            put(px.green);
                            put(px.blue);
                            n_rgb++;
                        end
                    end
                end
            end
            prev_px = px;
            if (last)
            begin
                repeat (7)
                    put(qoi_pkg::PAD_BYTE);
                put(qoi_pkg::PAD_LAST);
                expected_bytes[expected_bytes.size() - 1].image_end = 1'b1;
                clear_image();
                images++;
            end
            if (expected_bytes.size() > base)
                expected_bytes[expected_bytes.size() - 1].run_end = 1'b1;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("ERROR: %s", what);
        endtask

        task match_byte(logic [7:0] code, logic run_end, logic image_end);
            code_word_t want;
            if (expected_bytes.size() == 0)
            begin
                report($sformatf("byte %02h with nothing expected", code));
                return;
            end
            want = expected_bytes.pop_front();
            if (code !== want.code)
                report($sformatf("code byte %02h, expected %02h", code, want.code));
            if (run_end !== want.run_end)
                report($sformatf("run_end %b, expected %b on byte %02h",
                                 run_end, want.run_end, want.code));
            if (image_end !== want.image_end)
                report($sformatf("image_end %b, expected %b on byte %02h",
                                 image_end, want.image_end, want.code));
            bytes_ok++;
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    qoi_stream_board board;
    rx_mode_e        rx_mode     = RX_FREE;
    int unsigned     rx_cycle    = 0;
    int unsigned     idle_cycles = 0;
    int unsigned     burst_left  = 0;
    int unsigned     pixels_sent = 0;
    qoi_pkg::pixel_t src_px      = qoi_pkg::PIXEL_RESET;
    qoi_pkg::pixel_t palette[8];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    qoi_pixel_encoder_top #(
        .INDEX_ENTRIES(INDEX_ENTRIES)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 48 == 0)
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
        case (rx_mode)
            RX_FREE:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= (rx_cycle % 5 == 0);
            default:   m_tready <= (rx_cycle % 7) > 2;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.encode_pixel(qoi_pkg::pixel_t'(s_tdata), s_tlast);
            if (m_tvalid && m_tready)
                board.match_byte(m_tdata, m_tlast, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("qoi_pixel_encoder_top: mismatch");
                $finish;
            end
        end
    end

    function automatic qoi_pkg::pixel_t rgba(int r, int g, int b, int a);
        qoi_pkg::pixel_t p;
        p.red   = 8'(r);
        p.green = 8'(g);
        p.blue  = 8'(b);
        p.alpha = 8'(a);
        return p;
    endfunction

    task automatic send_pixel(qoi_pkg::pixel_t px, logic last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        pixels_sent++;
        src_px = last ? qoi_pkg::PIXEL_RESET : px;
    endtask

    task automatic wait_for_codes();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.expected_bytes.size() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    // mostly well-formed pixel sequences: runs, small deltas, index recalls
    task automatic random_image(int unsigned len);
        int unsigned     k = 0;
        int unsigned     reps;
        int unsigned     kind;
        int              dg;
        int              dr;
        int              db;
        qoi_pkg::pixel_t px;
        while (k < len)
        begin
            kind = $urandom_range(0, 99);
            px   = src_px;
            reps = 1;
            if (kind < 22)
            begin
                reps = ($urandom_range(0, 14) == 0) ? $urandom_range(55, 130)
                                                    : $urandom_range(1, 6);
                if (k + reps > len)
                    len = k + reps;
            end
            else if (kind < 40)
            begin
                px.red   = src_px.red + 8'($urandom_range(0, 3)) - 8'd2;
                px.green = src_px.green + 8'($urandom_range(0, 3)) - 8'd2;
                px.blue  = src_px.blue + 8'($urandom_range(0, 3)) - 8'd2;
            end
            else if (kind < 58)
            begin
                dg = $urandom_range(0, 63) - 32;
                dr = dg + $urandom_range(0, 15) - 8;
                db = dg + $urandom_range(0, 15) - 8;
                px.red   = src_px.red + 8'(dr);
                px.green = src_px.green + 8'(dg);
                px.blue  = src_px.blue + 8'(db);
            end
            else if (kind < 72)
                px = palette[$urandom_range(0, 7)];
            else if (kind < 82)
            begin
                px = $urandom;
                px.alpha = src_px.alpha;
            end
            else if (kind < 90)
                px.alpha = 8'($urandom);
            else
                px = $urandom;
            repeat (reps)
            begin
                send_pixel(px, k == len - 1);
                k++;
            end
        end
    endtask

    initial
    begin
        qoi_pkg::pixel_t px;
        int unsigned     reps;
        board = new();
        foreach (palette[i])
            palette[i] = $urandom;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every op, delta extremes, wraparound, runs ending on a final pixel
        send_pixel(rgba(0, 0, 0, 255), 1'b0);
        send_pixel(rgba(0, 0, 0, 255), 1'b0);
        send_pixel(rgba(1, 0, 255, 255), 1'b0);
        send_pixel(rgba(0, 0, 0, 0), 1'b0);
        send_pixel(rgba(10, 20, 30, 0), 1'b0);
        send_pixel(rgba(12, 25, 33, 0), 1'b0);
        send_pixel(rgba(10, 20, 30, 0), 1'b0);
        send_pixel(rgba(255, 255, 255, 255), 1'b0);
        send_pixel(rgba(215, 223, 230, 255), 1'b0);
        send_pixel(rgba(253, 254, 253, 255), 1'b0);
        send_pixel(rgba(251, 252, 251, 255), 1'b0);
        send_pixel(rgba(252, 253, 252, 255), 1'b0);
        send_pixel(rgba(0, 0, 0, 255), 1'b0);
        send_pixel(rgba(0, 0, 0, 255), 1'b0);
        send_pixel(rgba(0, 0, 0, 255), 1'b1);
        send_pixel(rgba(0, 0, 0, 255), 1'b0);
        send_pixel(rgba(5, 5, 5, 5), 1'b1);
        send_pixel(rgba(200, 100, 50, 255), 1'b1);
        send_pixel(rgba(0, 0, 0, 255), 1'b1);
        send_pixel(rgba(255, 255, 255, 0), 1'b0);
        send_pixel(rgba(0, 0, 0, 0), 1'b0);
        send_pixel(rgba(254, 1, 0, 0), 1'b1);
        wait_for_codes();

        // one image that runs past the cap at least once
        px   = $urandom;
        reps = $urandom_range(64, 140);
        for (int unsigned i = 0; i < reps; i++)
            send_pixel(px, i == reps - 1);

        while (pixels_sent < TOTAL_PIXELS)
        begin
            if ($urandom_range(0, 3) == 0)
                palette[$urandom_range(0, 7)] = $urandom;
            random_image(($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 40));
            if ($urandom_range(0, 7) == 0)
                wait_for_codes();
        end

        wait_for_codes();
        repeat (END_CYCLES) @(posedge clk);
        $display("Encoded %0d pixels in %0d images, %0d bytes compared.",
                 board.pixels, board.images, board.bytes_ok);
        $display("Ops: run %0d (%0d at cap), index %0d, diff %0d, luma %0d, rgb %0d, rgba %0d.",
                 board.n_run, board.n_cap, board.n_index, board.n_diff,
                 board.n_luma, board.n_rgb, board.n_rgba);
        if (board.errors == 0)
            $display("qoi_pixel_encoder_top: match");
        else
            $display("qoi_pixel_encoder_top: mismatch");
        $finish;
    end

endmodule

### qoi_pixel_encoder_top.f
hw/rtl/qoi_pkg.sv
hw/rtl/qoi_ram.sv
hw/rtl/qoi_pixel_encoder_top.sv
bench/qoi_pixel_encoder_top_tb.sv
